// ===== sv/bitmap_disk_neighbour_match_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the disk neighbour match block
// Concurrent checks that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BITMAP_DISK_NEIGHBOUR_MATCH_TOP_MACROS_SVH
`define BITMAP_DISK_NEIGHBOUR_MATCH_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define BDNM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bdnm: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define BDNM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bdnm: next-cycle check failed");
`else
`define BDNM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BDNM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/bdnm_pkg.sv =====
// ----------------------------------------------------------------------------
// bdnm_pkg
// Types, codes and the sequencer program of the disk neighbour match block.
// ----------------------------------------------------------------------------
package bdnm_pkg;

	localparam int BDNM_MAX_WIDTH  = 512;
	localparam int BDNM_MAX_HEIGHT = 512;
	localparam int BDNM_MAX_RADIUS = 16;

	localparam int ROW_W      = 9;
	localparam int COL_W      = 9;
	localparam int DIM_W      = 10;
	localparam int RSQ_W      = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 10'd512;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 10'd512;
	localparam logic [RSQ_W-1:0] RSQ_RESET    = 9'd4;

	// pixel word in the image RAM
	localparam int PIX_B = 0;
	localparam int PIX_A = 1;
	localparam int PIX_W = 2;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH     = 2'd0,
		CFG_HEIGHT    = 2'd1,
		CFG_RADIUS_SQ = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic             opcode;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             bit_a;
		logic             bit_b;
	} in_t;

	typedef struct packed {
		logic match_a;
		logic match_b;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'd0,
		ST_DECODE = 3'd1,
		ST_CENTER = 3'd2,
		ST_LATCH  = 3'd3,
		ST_SCAN   = 3'd4,
		ST_DRAIN  = 3'd5,
		ST_EMIT   = 3'd6,
		ST_WRITE  = 3'd7
	} step_t;

	typedef enum logic [2:0] {
		J_NEXT      = 3'd0,
		J_ALWAYS    = 3'd1,
		J_NO_START  = 3'd2,
		J_IS_WRITE  = 3'd3,
		J_SCAN_MORE = 3'd4
	} jcond_t;

	typedef struct packed {
		logic   idle;
		logic   ram_we;
		logic   rd_center;
		logic   latch_center;
		logic   scan;
		logic   acc_en;
		logic   emit;
		jcond_t cond;
		step_t  target;
	} ctrl_t;

	typedef struct packed {
		logic start;
		logic is_write;
		logic scan_more;
	} cond_t;

	// one control word per step
	function automatic ctrl_t ucode(step_t s);
		ctrl_t c;
		c = '0;
		c.cond = J_NEXT;
		c.target = ST_IDLE;
		case (s)
			ST_IDLE: begin
				c.idle = 1'b1;
				c.cond = J_NO_START;
				c.target = ST_IDLE;
			end
			ST_DECODE: begin
				c.cond = J_IS_WRITE;
				c.target = ST_WRITE;
			end
			ST_CENTER: begin
				c.rd_center = 1'b1;
			end
			ST_LATCH: begin
				c.latch_center = 1'b1;
			end
			ST_SCAN: begin
				c.scan = 1'b1;
				c.acc_en = 1'b1;
				c.cond = J_SCAN_MORE;
				c.target = ST_SCAN;
			end
			ST_DRAIN: begin
				c.acc_en = 1'b1;
			end
			ST_EMIT: begin
				c.emit = 1'b1;
				c.cond = J_ALWAYS;
				c.target = ST_IDLE;
			end
			ST_WRITE: begin
				c.ram_we = 1'b1;
				c.cond = J_ALWAYS;
				c.target = ST_IDLE;
			end
			default: begin
				c.cond = J_ALWAYS;
				c.target = ST_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

// ===== sv/bitmap_disk_neighbour_match_top.sv =====
// ----------------------------------------------------------------------------
// bitmap_disk_neighbour_match_top
// Sequence: a query steps through decode, center read, latch, the window
//   scan, drain and emit, then strobes done; a write steps through decode and
//   the RAM write, then returns to idle. A new request is taken only when idle;
//   the window scan reads one pixel a cycle through the single RAM port.
// Reset: arst_n clears the step counter and loads the register defaults;
//   image contents stay undefined until written. done cannot be held off.
// ----------------------------------------------------------------------------
`include "bitmap_disk_neighbour_match_top_macros.svh"

module bitmap_disk_neighbour_match_top
	import bdnm_pkg::*;
#(
	parameter int MAX_WIDTH  = BDNM_MAX_WIDTH,
	parameter int MAX_HEIGHT = BDNM_MAX_HEIGHT,
	parameter int MAX_RADIUS = BDNM_MAX_RADIUS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  in_t                   item,
	output logic                  done,
	output out_t                  result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
	// position math width: row/col plus window reach plus the saturated dims
	localparam int PW     = $clog2(1024 + 2 * MAX_RADIUS + MAX_WIDTH + MAX_HEIGHT) + 1;
	localparam int AX_W   = ADDR_W + PW;
	// window offset counters run 0 .. 2*MAX_RADIUS
	localparam int OW     = $clog2(2 * MAX_RADIUS + 1);
	localparam int DW     = $clog2(2 * MAX_RADIUS * MAX_RADIUS + 1);
	localparam int CW     = DW > RSQ_W ? DW : RSQ_W;

	localparam logic [OW-1:0] OFS_LAST = OW'(2 * MAX_RADIUS);
	localparam logic [OW-1:0] OFS_MID  = OW'(MAX_RADIUS);
	localparam logic [PW-1:0] REACH    = PW'(MAX_RADIUS);
	localparam logic [CW-1:0] RSQ_CAP  = CW'(MAX_RADIUS * MAX_RADIUS);

	// ------------------------------------------------------------------
	// Configuration registers (to be written only while idle; the block does not enforce this)
	// ------------------------------------------------------------------
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [RSQ_W-1:0] rsq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			rsq_q    <= RSQ_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_WIDTH:     width_q  <= cfg_data[DIM_W-1:0];
				CFG_HEIGHT:    height_q <= cfg_data[DIM_W-1:0];
				CFG_RADIUS_SQ: rsq_q    <= cfg_data[RSQ_W-1:0];
				default: begin
					// unused index: drop the write
				end
			endcase
		end
	end

	// Saturate dimensions and radius to what the store and window can hold.
	logic [PW-1:0] eff_w;
	logic [PW-1:0] eff_h;
	logic [CW-1:0] eff_rsq;

	assign eff_w   = (PW'(width_q) > PW'(MAX_WIDTH)) ? PW'(MAX_WIDTH) : PW'(width_q);
	assign eff_h   = (PW'(height_q) > PW'(MAX_HEIGHT)) ? PW'(MAX_HEIGHT) : PW'(height_q);
	assign eff_rsq = (CW'(rsq_q) > RSQ_CAP) ? RSQ_CAP : CW'(rsq_q);

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	ctrl_t ctrl;
	cond_t cond;
	logic  accept;

	logic [OW-1:0] ur_q;
	logic [OW-1:0] uc_q;

	assign busy   = !ctrl.idle;
	assign accept = start && ctrl.idle;

	in_t item_q;

	assign cond.start     = start;
	assign cond.is_write  = (item_q.opcode == OP_WRITE);
	assign cond.scan_more = !((ur_q == OFS_LAST) && (uc_q == OFS_LAST));

	bdnm_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.cond  (cond),
		.ctrl  (ctrl)
	);

	// Hold the request for the whole run of the program.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
	end

	// ------------------------------------------------------------------
	// Addressed pixel and window position
	// ------------------------------------------------------------------
	logic              in_image;
	logic [ADDR_W-1:0] center_addr;

	assign in_image    = (PW'(item_q.row) < eff_h) && (PW'(item_q.col) < eff_w);
	assign center_addr = ADDR_W'(AX_W'(item_q.row) * AX_W'(MAX_WIDTH) + AX_W'(item_q.col));

	logic [PW-1:0]     rr_raw;
	logic [PW-1:0]     cc_raw;
	logic [PW-1:0]     rr;
	logic [PW-1:0]     cc;
	logic              pos_ok;
	logic [OW-1:0]     ar;
	logic [OW-1:0]     ac;
	logic [DW-1:0]     ar_w;
	logic [DW-1:0]     ac_w;
	logic [DW-1:0]     dist_sq;
	logic              in_disk;
	logic              win_ok;
	logic [ADDR_W-1:0] win_addr;

	// Window position is the query pixel plus (offset - MAX_RADIUS); the
	// raw sum stays non-negative so the clip at the top and left edges is a
	// compare against the reach.
	assign rr_raw = PW'(item_q.row) + PW'(ur_q);
	assign cc_raw = PW'(item_q.col) + PW'(uc_q);
	assign rr     = rr_raw - REACH;
	assign cc     = cc_raw - REACH;
	assign pos_ok = (rr_raw >= REACH) && (rr < eff_h) && (cc_raw >= REACH) && (cc < eff_w);

	assign ar      = (ur_q >= OFS_MID) ? (ur_q - OFS_MID) : (OFS_MID - ur_q);
	assign ac      = (uc_q >= OFS_MID) ? (uc_q - OFS_MID) : (OFS_MID - uc_q);
	assign ar_w    = DW'(ar);
	assign ac_w    = DW'(ac);
	assign dist_sq = ar_w * ar_w + ac_w * ac_w;
	assign in_disk = CW'(dist_sq) <= eff_rsq;
	assign win_ok  = pos_ok && in_disk;

	assign win_addr = win_ok ? ADDR_W'(AX_W'(rr) * AX_W'(MAX_WIDTH) + AX_W'(cc)) : '0;

	// ------------------------------------------------------------------
	// Image store: A and B share one word per pixel
	// ------------------------------------------------------------------
	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [PIX_W-1:0]  ram_wdata;
	logic [PIX_W-1:0]  ram_rdata;

	assign ram_we   = ctrl.ram_we && in_image;
	assign ram_addr = (ctrl.ram_we || ctrl.rd_center) ? center_addr : win_addr;

	always_comb begin
		ram_wdata        = '0;
		ram_wdata[PIX_A] = item_q.bit_a;
		ram_wdata[PIX_B] = item_q.bit_b;
	end

	bdnm_ram #(
		.WIDTH(PIX_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// ------------------------------------------------------------------
	// Scan counters, read tag and accumulators
	// ------------------------------------------------------------------
	logic pend_s1;
	logic ca_q;
	logic cb_q;
	logic any_a_q;
	logic any_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ur_q    <= '0;
			uc_q    <= '0;
			pend_s1 <= 1'b0;
		end else begin
			// tag the read issued this cycle so its data is counted next cycle
			pend_s1 <= ctrl.scan && win_ok;
			if (ctrl.latch_center) begin
				ur_q <= '0;
				uc_q <= '0;
			end else if (ctrl.scan) begin
				if (uc_q == OFS_LAST) begin
					uc_q <= '0;
					ur_q <= ur_q + OW'(1);
				end else begin
					uc_q <= uc_q + OW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.latch_center) begin
			// center read was issued in the step before; outside pixels read as clear
			ca_q    <= in_image && ram_rdata[PIX_A];
			cb_q    <= in_image && ram_rdata[PIX_B];
			any_a_q <= 1'b0;
			any_b_q <= 1'b0;
		end else if (ctrl.acc_en && pend_s1) begin
			any_a_q <= any_a_q | ram_rdata[PIX_A];
			any_b_q <= any_b_q | ram_rdata[PIX_B];
		end
	end

	// ------------------------------------------------------------------
	// Result: one-cycle strobe, receiver cannot stall
	// ------------------------------------------------------------------
	assign done           = ctrl.emit;
	assign result.match_a = ca_q && any_b_q;
	assign result.match_b = cb_q && any_a_q;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	// a result only comes out of a running program
	`BDNM_ASSERT_SAME(a_done_busy, clk, arst_n, done, busy)
	// an accepted request starts the program
	`BDNM_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	// the strobe lasts exactly one cycle
	`BDNM_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)
	// never write the store in the middle of a window scan
	`BDNM_ASSERT_SAME(a_no_write_scan, clk, arst_n, ram_we, !ctrl.scan && !pend_s1)

endmodule

// ===== sv/bdnm_ram.sv =====
// ----------------------------------------------------------------------------
// bdnm_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bdnm_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                          wdata,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== sv/bdnm_seq.sv =====
// ----------------------------------------------------------------------------
// bdnm_seq
// Step counter and program table; emits one control word per cycle.
// ----------------------------------------------------------------------------
module bdnm_seq
	import bdnm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cond_t cond,
	output ctrl_t ctrl
);

	step_t step_q;
	step_t step_d;
	logic  take;

	assign ctrl = ucode(step_q);

	always_comb begin
		case (ctrl.cond)
			J_NEXT:      take = 1'b0;
			J_ALWAYS:    take = 1'b1;
			J_NO_START:  take = !cond.start;
			J_IS_WRITE:  take = cond.is_write;
			J_SCAN_MORE: take = cond.scan_more;
			default:     take = 1'b1;
		endcase
		step_d = take ? ctrl.target : step_t'(step_q + 3'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

// ===== test/tb_bitmap_disk_neighbour_match_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disk neighbour match testbench
// Loads pixel pairs into both images, then queries pixels and checks the two
// match bits against an in-bench model of the clipped disk search. The run
// goes through many image sizes and radii. Every pixel that a query window can
// touch is loaded first.
// ----------------------------------------------------------------------------
module tb_bitmap_disk_neighbour_match_top;
	import bdnm_pkg::*;

	localparam int PIXELS         = BDNM_MAX_WIDTH * BDNM_MAX_HEIGHT;
	localparam int COORD_MAX      = (1 << ROW_W) - 1;
	localparam int IDLE_PCT       = 35;
	// Let writes settle before a register write.
	localparam int SETTLE_CYCLES  = 16;
	// A query scans (2R+1)^2 pixels before it strobes done.
	localparam int DRAIN_CYCLES   = 1200;
	// Slowest quiet stretch: one full query scan plus a sender gap, taken 5x.
	localparam int WATCHDOG_LIMIT = 6000;

	typedef struct {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		out_t             bits;
	} match_expect_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	in_t                   item = '0;
	logic                  done;
	out_t                  result;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// model state: both images and the raw register values
	bit          img_a [PIXELS];
	bit          img_b [PIXELS];
	bit          loaded [PIXELS];
	int unsigned width_reg = WIDTH_RESET;
	int unsigned height_reg = HEIGHT_RESET;
	int unsigned radius_sq_reg = RSQ_RESET;

	in_t           op_queue [$];
	match_expect_t match_queue [$];
	logic          req_taken = 1'b0;
	bit            sender_pauses = 1'b1;
	int            mismatches = 0;
	int            quiet_cycles = 0;

	bitmap_disk_neighbour_match_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Clamp the raw registers the way the block does.
	function automatic int eff_width();
		return (width_reg > BDNM_MAX_WIDTH) ? BDNM_MAX_WIDTH : int'(width_reg);
	endfunction

	function automatic int eff_height();
		return (height_reg > BDNM_MAX_HEIGHT) ? BDNM_MAX_HEIGHT : int'(height_reg);
	endfunction

	function automatic int eff_radius_sq();
		int lim;
		lim = BDNM_MAX_RADIUS * BDNM_MAX_RADIUS;
		return (radius_sq_reg > lim) ? lim : int'(radius_sq_reg);
	endfunction

	// True when the other image has a set pixel inside the clipped disk.
	function automatic bit set_pixel_near(input bit in_b, input int r, input int c);
		int w, h, rsq, rr, cc, addr;
		w = eff_width();
		h = eff_height();
		rsq = eff_radius_sq();
		for (int dr = -BDNM_MAX_RADIUS; dr <= BDNM_MAX_RADIUS; dr++) begin
			for (int dc = -BDNM_MAX_RADIUS; dc <= BDNM_MAX_RADIUS; dc++) begin
				rr = r + dr;
				cc = c + dc;
				if (rr >= 0 && rr < h && cc >= 0 && cc < w && dr * dr + dc * dc <= rsq) begin
					addr = rr * BDNM_MAX_WIDTH + cc;
					if (in_b ? img_b[addr] : img_a[addr])
						return 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	// Apply one accepted request to the model; queue the match bits of a query.
	function automatic void apply_pixel_op(input in_t req);
		int r, c, addr;
		bit in_image;
		match_expect_t want;
		r = int'(req.row);
		c = int'(req.col);
		addr = r * BDNM_MAX_WIDTH + c;
		in_image = (r < eff_height()) && (c < eff_width());
		if (req.opcode == OP_WRITE) begin
			if (in_image) begin
				img_a[addr] = req.bit_a;
				img_b[addr] = req.bit_b;
			end
		end else begin
			want.row = req.row;
			want.col = req.col;
			want.bits = '0;
			if (in_image) begin
				want.bits.match_a = img_a[addr] && set_pixel_near(1'b1, r, c);
				want.bits.match_b = img_b[addr] && set_pixel_near(1'b0, r, c);
			end
			match_queue.insert(match_queue.size(), want);
		end
	endfunction

	// Queue one request; track which pixels hold defined data.
	function automatic void push_op(input opcode_t op, input int r, input int c,
			input bit a, input bit b);
		in_t req;
		req.opcode = op;
		req.row = ROW_W'(r);
		req.col = COL_W'(c);
		req.bit_a = a;
		req.bit_b = b;
		if (op == OP_WRITE && r < eff_height() && c < eff_width())
			loaded[r * BDNM_MAX_WIDTH + c] = 1'b1;
		op_queue.insert(op_queue.size(), req);
	endfunction

	function automatic bit roll_pct(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// Load every unloaded pixel of the clipped window around (r, c).
	function automatic int load_window(input int r, input int c, input int dens_a,
			input int dens_b);
		int n;
		n = 0;
		for (int rr = r - BDNM_MAX_RADIUS; rr <= r + BDNM_MAX_RADIUS; rr++) begin
			for (int cc = c - BDNM_MAX_RADIUS; cc <= c + BDNM_MAX_RADIUS; cc++) begin
				if (rr >= 0 && rr < eff_height() && cc >= 0 && cc < eff_width() &&
						!loaded[rr * BDNM_MAX_WIDTH + cc]) begin
					push_op(OP_WRITE, rr, cc, roll_pct(dens_a), roll_pct(dens_b));
					n++;
				end
			end
		end
		return n;
	endfunction

	// Pick where the query patch sits: either edge or anywhere between.
	function automatic int pick_base(input int dim, input int span);
		case ($urandom_range(0, 2))
			0: begin
				return 0;
			end
			1: begin
				return dim - span;
			end
			default: begin
				return $urandom_range(0, dim - span);
			end
		endcase
	endfunction

	// Block until every request is taken and every match bit has come back.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (op_queue.size() != 0 || start || done || match_queue.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		case (idx)
			CFG_WIDTH: begin
				width_reg = value % (1 << DIM_W);
			end
			CFG_HEIGHT: begin
				height_reg = value % (1 << DIM_W);
			end
			CFG_RADIUS_SQ: begin
				radius_sq_reg = value % (1 << RSQ_W);
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Reconfigure while idle, then hand control back on a rising edge.
	task automatic set_config(input int unsigned w, input int unsigned h,
			input int unsigned rsq);
		wait_drained();
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
		write_reg(CFG_RADIUS_SQ, rsq);
		@(posedge clk);
	endtask

	// One random phase: queries cluster on a small patch so that window loads
	// stay cheap; writes rewrite pixels around it; a few requests miss the image.
	task automatic run_phase(input int unsigned w, input int unsigned h,
			input int unsigned rsq, input int n_ops, input int dens_a, input int dens_b,
			input bit steady);
		int gw, gh, span_r, span_c, base_r, base_c, lo_r, hi_r, lo_c, hi_c;
		int count, roll, r, c;
		set_config(w, h, rsq);
		sender_pauses = !steady;
		gw = eff_width();
		gh = eff_height();
		span_r = (gh < 6) ? gh : 6;
		span_c = (gw < 6) ? gw : 6;
		base_r = pick_base(gh, span_r);
		base_c = pick_base(gw, span_c);
		lo_r = (base_r > BDNM_MAX_RADIUS) ? base_r - BDNM_MAX_RADIUS : 0;
		lo_c = (base_c > BDNM_MAX_RADIUS) ? base_c - BDNM_MAX_RADIUS : 0;
		hi_r = base_r + span_r - 1 + BDNM_MAX_RADIUS;
		hi_c = base_c + span_c - 1 + BDNM_MAX_RADIUS;
		if (hi_r > gh - 1)
			hi_r = gh - 1;
		if (hi_c > gw - 1)
			hi_c = gw - 1;
		count = 0;
		while (count < n_ops) begin
			roll = $urandom_range(0, 99);
			if (roll < 10 && (gh < BDNM_MAX_HEIGHT || gw < BDNM_MAX_WIDTH)) begin
				// off the image: writes drop, queries answer zero
				if (gh < BDNM_MAX_HEIGHT) begin
					r = $urandom_range(gh, COORD_MAX);
					c = $urandom_range(0, COORD_MAX);
				end else begin
					r = $urandom_range(0, COORD_MAX);
					c = $urandom_range(gw, COORD_MAX);
				end
				if (roll < 5) begin
					push_op(OP_WRITE, r, c, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
				end else begin
					push_op(OP_QUERY, r, c, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
					count++;
				end
			end else if (roll < 55) begin
				r = base_r + $urandom_range(0, span_r - 1);
				c = base_c + $urandom_range(0, span_c - 1);
				count += load_window(r, c, dens_a, dens_b);
				push_op(OP_QUERY, r, c, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				count++;
			end else begin
				r = $urandom_range(lo_r, hi_r);
				c = $urandom_range(lo_c, hi_c);
				push_op(OP_WRITE, r, c, roll_pct(dens_a), roll_pct(dens_b));
				count++;
			end
		end
	endtask

	// Driver: present the next request on the falling edge; hold it until taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || req_taken) begin
			if (op_queue.size() != 0 && !(sender_pauses && roll_pct(IDLE_PCT))) begin
				item <= op_queue.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: advance the model on every taken request, check every strobe.
	always @(posedge clk) begin
		match_expect_t want;
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			req_taken <= start && !busy;
			if (start && !busy)
				apply_pixel_op(item);
			if (done) begin
				if (match_queue.size() == 0) begin
					$display("%0t: unexpected result %b with no query outstanding",
						$time, result);
					mismatches++;
				end else begin
					want = match_queue.pop_front();
					if (result.match_a !== want.bits.match_a) begin
						$display("%0t: query (%0d,%0d) match_a expected %b actual %b",
							$time, want.row, want.col, want.bits.match_a, result.match_a);
						mismatches++;
					end
					if (result.match_b !== want.bits.match_b) begin
						$display("%0t: query (%0d,%0d) match_b expected %b actual %b",
							$time, want.row, want.col, want.bits.match_b, result.match_b);
						mismatches++;
					end
				end
			end
		end
	end

	// Watchdog: drop the run if nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: timeout, no request or result for %0d cycles",
					$time, quiet_cycles);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset sizes: hit the four corners, covering every address bit.
		push_op(OP_WRITE, 0, 0, 1'b1, 1'b0);
		push_op(OP_WRITE, COORD_MAX, COORD_MAX, 1'b0, 1'b1);
		push_op(OP_WRITE, 0, COORD_MAX, 1'b1, 1'b1);
		push_op(OP_WRITE, COORD_MAX, 0, 1'b0, 1'b0);

		// Zero width: nothing is in use, writes drop and queries answer zero.
		set_config(0, 3, 0);
		push_op(OP_WRITE, 1, 1, 1'b1, 1'b1);
		push_op(OP_QUERY, 0, 0, 1'b1, 1'b1);
		push_op(OP_QUERY, COORD_MAX, COORD_MAX, 1'b0, 1'b0);

		// Zero height.
		set_config(3, 0, 0);
		push_op(OP_QUERY, 1, 1, 1'b0, 1'b1);

		// Tiny 3x3 image with a fixed pattern, queries at center, three corners and
		// just off the bottom and right edges.
		set_config(3, 3, 1);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				push_op(OP_WRITE, r, c, r == c, ((r + c) % 2 == 1) || (r == 2 && c == 2));
		push_op(OP_QUERY, 1, 1, 1'b1, 1'b0);
		push_op(OP_QUERY, 0, 0, 1'b0, 1'b1);
		push_op(OP_QUERY, 2, 2, 1'b1, 1'b1);
		push_op(OP_QUERY, 0, 2, 1'b0, 1'b0);
		push_op(OP_QUERY, 3, 0, 1'b1, 1'b1);
		push_op(OP_QUERY, 0, 3, 1'b0, 1'b0);

		// Random phases across sizes and radii, extremes included.
		run_phase(1, 1, 0, 12, 50, 50, 1'b0);
		run_phase(4, 5, 1, 40, 40, 40, 1'b0);
		run_phase(7, 6, 2, 45, 30, 30, 1'b0);
		// radius register at all ones: clamps to the largest disk
		run_phase(2, 17, 1023, 45, 15, 15, 1'b0);
		// width above the maximum clamps; no sender gaps for two phases
		run_phase(1023, 2, 256, 50, 10, 10, 1'b1);
		run_phase(3, 512, 200, 50, 10, 10, 1'b1);
		run_phase(8, 9, 20, 60, 20, 20, 1'b0);
		run_phase(12, 8, 5, 50, 8, 8, 1'b0);
		// zero radius: only a pixel set in both images matches
		run_phase(6, 9, 0, 40, 50, 50, 1'b0);
		run_phase(16, 1, 256, 30, 15, 15, 1'b0);
		run_phase(8, 8, 3, 60, 60, 60, 1'b0);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
